>>> src/pvs_pkg.sv
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared codes and types of the particle half-step integrator.
// ----------------------------------------------------------------------------
package pvs_pkg;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DT_POSITION   = 3'd0,
        CFG_DT_FORCE_HALF = 3'd1,
        CFG_SPEED_LIMIT   = 3'd2,
        CFG_SMOOTHING     = 3'd3
    } t_cfg_index;

    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

>>> src/pvs_divider.sv
// ----------------------------------------------------------------------------
// pvs_divider
// Pipelined restoring divider, one quotient bit per stage, with lanes that
// share one divisor and a sideband word that travels with the operands.
// ----------------------------------------------------------------------------
module pvs_divider #(
    parameter int NUM_BITS  = 47,
    parameter int DEN_BITS  = 31,
    parameter int QUO_BITS  = 31,
    parameter int LANES     = 1,
    parameter int SIDE_BITS = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pvs_pkg::t_stage_ctl                i_ctl,
    input  logic [LANES-1:0][NUM_BITS-1:0]     i_num,
    input  logic [DEN_BITS-1:0]                i_den,
    input  logic [SIDE_BITS-1:0]               i_side,
    output logic                               o_valid,
    output logic [LANES-1:0][QUO_BITS-1:0]     o_quo,
    output logic [SIDE_BITS-1:0]               o_side
);
    import pvs_pkg::*;

    logic                              r_valid [1:QUO_BITS];
    logic [LANES-1:0][QUO_BITS-1:0]    r_quo   [1:QUO_BITS];
    logic [SIDE_BITS-1:0]              r_side  [1:QUO_BITS];
    logic [LANES-1:0][DEN_BITS-1:0]    r_rem   [1:QUO_BITS-1];
    logic [LANES-1:0][QUO_BITS-1:0]    r_low   [1:QUO_BITS-1];
    logic [DEN_BITS-1:0]               r_den   [1:QUO_BITS-1];

    for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
        logic                           w_valid;
        logic [LANES-1:0][DEN_BITS-1:0] w_rem;
        logic [LANES-1:0][DEN_BITS-1:0] n_rem;
        logic [LANES-1:0][QUO_BITS-1:0] w_low;
        logic [LANES-1:0][QUO_BITS-1:0] n_low;
        logic [LANES-1:0][QUO_BITS-1:0] w_quo;
        logic [LANES-1:0][QUO_BITS-1:0] n_quo;
        logic [DEN_BITS-1:0]            w_den;
        logic [SIDE_BITS-1:0]           w_side;

        if (s == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    w_rem[l] = DEN_BITS'(i_num[l] >> QUO_BITS);
                    w_low[l] = i_num[l][QUO_BITS-1:0];
                end
            end
            assign w_quo   = '0;
            assign w_valid = i_ctl.valid;
            assign w_den   = i_den;
            assign w_side  = i_side;
        end else begin : g_next
            assign w_rem   = r_rem[s];
            assign w_low   = r_low[s];
            assign w_quo   = r_quo[s];
            assign w_valid = r_valid[s];
            assign w_den   = r_den[s];
            assign w_side  = r_side[s];
        end

        always_comb begin
            logic [DEN_BITS:0] trial;
            for (int l = 0; l < LANES; l++) begin
                trial = {w_rem[l], w_low[l][QUO_BITS-1]};
                if (trial >= {1'b0, w_den}) begin
                    n_rem[l] = DEN_BITS'(trial - {1'b0, w_den});
                    n_quo[l] = {w_quo[l][QUO_BITS-2:0], 1'b1};
                end else begin
                    n_rem[l] = DEN_BITS'(trial);
                    n_quo[l] = {w_quo[l][QUO_BITS-2:0], 1'b0};
                end
                n_low[l] = w_low[l] << 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_valid[s+1] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_quo[s+1]  <= n_quo;
                r_side[s+1] <= w_side;
            end
        end

        if (s < QUO_BITS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_rem[s+1] <= n_rem;
                    r_low[s+1] <= n_low;
                    r_den[s+1] <= w_den;
                end
            end
        end
    end

    assign o_valid = r_valid[QUO_BITS];
    assign o_quo   = r_quo[QUO_BITS];
    assign o_side  = r_side[QUO_BITS];

endmodule

>>> src/pvs_isqrt.sv
// ----------------------------------------------------------------------------
// pvs_isqrt
// Pipelined integer square root, one root bit per stage, floor result, with a
// sideband word that travels with the operand.
// ----------------------------------------------------------------------------
module pvs_isqrt #(
    parameter int ROOT_BITS = 32,
    parameter int SIDE_BITS = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pvs_pkg::t_stage_ctl    i_ctl,
    input  logic [2*ROOT_BITS-1:0] i_x,
    input  logic [SIDE_BITS-1:0]   i_side,
    output logic                   o_valid,
    output logic [ROOT_BITS-1:0]   o_root,
    output logic [SIDE_BITS-1:0]   o_side
);
    import pvs_pkg::*;

    localparam int XB = 2 * ROOT_BITS;
    localparam int RB = ROOT_BITS + 2;

    logic                 r_valid [1:ROOT_BITS];
    logic [ROOT_BITS-1:0] r_root  [1:ROOT_BITS];
    logic [SIDE_BITS-1:0] r_side  [1:ROOT_BITS];
    logic [XB-1:0]        r_x     [1:ROOT_BITS-1];
    logic [RB-1:0]        r_rem   [1:ROOT_BITS-1];

    for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
        logic                 w_valid;
        logic [XB-1:0]        w_x;
        logic [RB-1:0]        w_rem;
        logic [ROOT_BITS-1:0] w_root;
        logic [SIDE_BITS-1:0] w_side;
        logic [RB-1:0]        n_rem;
        logic [ROOT_BITS-1:0] n_root;
        logic [XB-1:0]        n_x;

        if (s == 0) begin : g_first
            assign w_valid = i_ctl.valid;
            assign w_x     = i_x;
            assign w_rem   = '0;
            assign w_root  = '0;
            assign w_side  = i_side;
        end else begin : g_next
            assign w_valid = r_valid[s];
            assign w_x     = r_x[s];
            assign w_rem   = r_rem[s];
            assign w_root  = r_root[s];
            assign w_side  = r_side[s];
        end

        always_comb begin
            logic [RB+1:0] acc;
            logic [RB+1:0] trial;
            acc   = {w_rem, w_x[XB-1:XB-2]};
            trial = (RB+2)'({w_root, 2'b01});
            if (acc >= trial) begin
                n_rem  = RB'(acc - trial);
                n_root = {w_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                n_rem  = RB'(acc);
                n_root = {w_root[ROOT_BITS-2:0], 1'b0};
            end
            n_x = w_x << 2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_valid[s+1] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_root[s+1] <= n_root;
                r_side[s+1] <= w_side;
            end
        end

        if (s < ROOT_BITS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_x[s+1]   <= n_x;
                    r_rem[s+1] <= n_rem;
                end
            end
        end
    end

    assign o_valid = r_valid[ROOT_BITS];
    assign o_root  = r_root[ROOT_BITS];
    assign o_side  = r_side[ROOT_BITS];

endmodule

>>> src/particle_verlet_step_with_speed_cap.sv
// ----------------------------------------------------------------------------
// particle_verlet_step_with_speed_cap
// Velocity Verlet half step of one particle per word, with a speed cap,
// a full-step velocity estimate, position and energy increments.
//
//   Channel  Direction  Handshake               Contents
//   input    in         i_valid / o_stall       operation, mass, force, vel,
//                                               smoothed vel, energy rate
//   output   out        o_valid / i_stall       new vel, est vel, move,
//                                               energy step, was_capped
//   config   in         i_cfg_valid/o_cfg_ready register index and data
//
// One word enters per cycle unless the pipeline is stalled; each word runs
// through the mass divider, the speed square root and the rescaling divider,
// each one bit per stage. Reset is synchronous and active low; it clears the
// valid bits and the configuration registers. A stall at the output while
// o_valid is high freezes the whole pipeline and raises o_stall in the same cycle.
// ----------------------------------------------------------------------------
module particle_verlet_step_with_speed_cap #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_operation,
    input  logic [WORD_BITS-2:0]                i_mass,
    input  logic signed [WORD_BITS-1:0]         i_force_x,
    input  logic signed [WORD_BITS-1:0]         i_force_y,
    input  logic signed [WORD_BITS-1:0]         i_force_z,
    input  logic signed [WORD_BITS-1:0]         i_vel_x,
    input  logic signed [WORD_BITS-1:0]         i_vel_y,
    input  logic signed [WORD_BITS-1:0]         i_vel_z,
    input  logic signed [WORD_BITS-1:0]         i_smooth_x,
    input  logic signed [WORD_BITS-1:0]         i_smooth_y,
    input  logic signed [WORD_BITS-1:0]         i_smooth_z,
    input  logic signed [WORD_BITS-1:0]         i_energy_rate,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [WORD_BITS-1:0]         o_new_vel_x,
    output logic signed [WORD_BITS-1:0]         o_new_vel_y,
    output logic signed [WORD_BITS-1:0]         o_new_vel_z,
    output logic signed [WORD_BITS-1:0]         o_est_vel_x,
    output logic signed [WORD_BITS-1:0]         o_est_vel_y,
    output logic signed [WORD_BITS-1:0]         o_est_vel_z,
    output logic signed [WORD_BITS-1:0]         o_move_x,
    output logic signed [WORD_BITS-1:0]         o_move_y,
    output logic signed [WORD_BITS-1:0]         o_move_z,
    output logic signed [WORD_BITS-1:0]         o_energy_step,
    output logic                                o_was_capped,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pvs_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [WORD_BITS-2:0]                i_cfg_data
);
    import pvs_pkg::*;

    localparam int W      = WORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int DIV_N  = W - 1 + F;
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic                 op;
        logic                 ovf;
        logic [2:0][W-1:0]    frc;
        logic [2:0][W-1:0]    vel;
        logic [2:0][W-1:0]    smo;
        logic [W-1:0]         er;
    } t_in_side;

    typedef struct packed {
        logic                 op;
        logic [2:0][2*W-1:0]  prod;
        logic [2:0][W-1:0]    vel;
        logic [2:0][W-1:0]    smo;
        logic [W-1:0]         er;
    } t_mul;

    typedef struct packed {
        logic                 op;
        logic [2:0][W-1:0]    dv;
        logic [2:0][W-1:0]    v;
        logic [2:0][W-1:0]    smo;
        logic [W-1:0]         er;
    } t_vel;

    typedef struct packed {
        logic                 op;
        logic [2:0]           neg;
        logic [2:0][W-1:0]    mag;
        logic [2:0][2*W-1:0]  sq;
        logic [2:0][W-1:0]    dv;
        logic [2:0][W-1:0]    v;
        logic [2:0][W-1:0]    smo;
        logic [W-1:0]         er;
    } t_abs;

    typedef struct packed {
        logic                 op;
        logic                 capped;
        logic [2:0]           neg;
        logic [2:0][2*W-2:0]  prod;
        logic [2:0][W-1:0]    dv;
        logic [2:0][W-1:0]    v;
        logic [2:0][W-1:0]    smo;
        logic [W-1:0]         er;
    } t_sum;

    typedef struct packed {
        logic                 op;
        logic                 capped;
        logic [2:0]           neg;
        logic [2:0][W-1:0]    dv;
        logic [2:0][W-1:0]    v;
        logic [2:0][W-1:0]    smo;
        logic [W-1:0]         er;
    } t_cap;

    typedef struct packed {
        logic                 op;
        logic                 capped;
        logic [2:0][W-1:0]    vfin;
        logic [2:0][W-1:0]    est;
        logic [2:0][W:0]      base;
        logic [W-1:0]         er;
    } t_fin;

    typedef struct packed {
        logic                 op;
        logic                 capped;
        logic [2:0][W-1:0]    vfin;
        logic [2:0][W-1:0]    est;
        logic [2:0][2*W:0]    mv;
        logic [2*W-1:0]       ep;
    } t_prd;

    typedef struct packed {
        logic [2:0][W-1:0]    new_vel;
        logic [2:0][W-1:0]    est_vel;
        logic [2:0][W-1:0]    move;
        logic [W-1:0]         energy;
        logic                 capped;
    } t_out;

    function automatic logic signed [W-1:0] f_sat(input logic signed [2*W:0] x);
        logic [W+1:0] hi;
        hi = x[2*W:W-1];
        if ((hi == '0) || (hi == '1)) begin
            f_sat = x[W-1:0];
        end else if (x[2*W]) begin
            f_sat = WMIN;
        end else begin
            f_sat = WMAX;
        end
    endfunction

    logic [W-2:0]   r_dt_position;
    logic [W-2:0]   r_dt_force_half;
    logic [W-2:0]   r_speed_limit;
    logic           r_smoothing_enable;
    logic [2*W-3:0] r_limit_sq;

    logic w_en;
    assign w_en        = !(o_valid && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt_position      <= '0;
            r_dt_force_half    <= '0;
            r_speed_limit      <= '0;
            r_smoothing_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DT_POSITION:   r_dt_position      <= i_cfg_data;
                CFG_DT_FORCE_HALF: r_dt_force_half    <= i_cfg_data;
                CFG_SPEED_LIMIT:   r_speed_limit      <= i_cfg_data;
                CFG_SMOOTHING:     r_smoothing_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit_sq <= r_speed_limit * r_speed_limit;
    end

    // Mass division.
    logic [DIV_N-1:0]       w_dividend;
    logic                   w_ovf;
    logic [0:0][DIV_N-1:0]  w_div_num;
    t_in_side               w_in_side;
    t_stage_ctl             w_ctl_in;
    logic                   w_d1_valid;
    logic [0:0][W-2:0]      w_d1_quo;
    logic [$bits(t_in_side)-1:0] w_d1_side;
    t_in_side               w_s1;

    assign w_dividend   = {r_dt_force_half, {F{1'b0}}};
    assign w_ovf        = (w_dividend >> (W - 1)) >= DIV_N'(i_mass);
    assign w_div_num[0] = w_ovf ? '0 : w_dividend;
    assign w_ctl_in     = '{en: w_en, valid: i_valid};

    always_comb begin
        w_in_side.op     = i_operation;
        w_in_side.ovf    = w_ovf;
        w_in_side.frc[0] = i_force_x;
        w_in_side.frc[1] = i_force_y;
        w_in_side.frc[2] = i_force_z;
        w_in_side.vel[0] = i_vel_x;
        w_in_side.vel[1] = i_vel_y;
        w_in_side.vel[2] = i_vel_z;
        w_in_side.smo[0] = i_smooth_x;
        w_in_side.smo[1] = i_smooth_y;
        w_in_side.smo[2] = i_smooth_z;
        w_in_side.er     = i_energy_rate;
    end

    pvs_divider #(
        .NUM_BITS  (DIV_N),
        .DEN_BITS  (W - 1),
        .QUO_BITS  (W - 1),
        .LANES     (1),
        .SIDE_BITS ($bits(t_in_side))
    ) u_mass_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_in),
        .i_num   (w_div_num),
        .i_den   (i_mass),
        .i_side  (w_in_side),
        .o_valid (w_d1_valid),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side)
    );

    assign w_s1 = w_d1_side;

    // Stage A: force times dtfm.
    logic [W-2:0] w_dtfm;
    t_mul         n_a;
    t_mul         r_a;
    logic         r_a_valid;

    assign w_dtfm = w_s1.ovf ? {(W-1){1'b1}} : w_d1_quo[0];

    always_comb begin
        n_a.op  = w_s1.op;
        n_a.vel = w_s1.vel;
        n_a.smo = w_s1.smo;
        n_a.er  = w_s1.er;
        for (int i = 0; i < 3; i++) begin
            n_a.prod[i] = $signed({1'b0, w_dtfm}) * $signed(w_s1.frc[i]);
        end
    end

    // Stage B: velocity increment and updated velocity.
    t_vel n_b;
    t_vel r_b;
    logic r_b_valid;

    always_comb begin
        logic signed [W-1:0] dv;
        n_b.op  = r_a.op;
        n_b.smo = r_a.smo;
        n_b.er  = r_a.er;
        for (int i = 0; i < 3; i++) begin
            dv        = f_sat((2*W+1)'($signed(r_a.prod[i]) >>> F));
            n_b.dv[i] = dv;
            n_b.v[i]  = f_sat((2*W+1)'($signed(r_a.vel[i])) + (2*W+1)'(dv));
        end
    end

    // Stage C: magnitudes and squares.
    t_abs n_c;
    t_abs r_c;
    logic r_c_valid;

    always_comb begin
        logic [W-1:0] m;
        n_c.op  = r_b.op;
        n_c.dv  = r_b.dv;
        n_c.v   = r_b.v;
        n_c.smo = r_b.smo;
        n_c.er  = r_b.er;
        for (int i = 0; i < 3; i++) begin
            n_c.neg[i] = r_b.v[i][W-1];
            m          = r_b.v[i][W-1] ? (~r_b.v[i] + W'(1)) : r_b.v[i];
            n_c.mag[i] = m;
            n_c.sq[i]  = (2*W)'(m) * (2*W)'(m);
        end
    end

    // Stage D: squared speed, cap decision, scaled magnitudes.
    t_sum         n_d;
    t_sum         r_d;
    logic [2*W-1:0] n_d_vsq;
    logic [2*W-1:0] r_d_vsq;
    logic         r_d_valid;

    always_comb begin
        n_d_vsq    = r_c.sq[0] + r_c.sq[1] + r_c.sq[2];
        n_d.op     = r_c.op;
        n_d.capped = (r_speed_limit != '0) && (n_d_vsq > (2*W)'(r_limit_sq));
        n_d.neg    = r_c.neg;
        n_d.dv     = r_c.dv;
        n_d.v      = r_c.v;
        n_d.smo    = r_c.smo;
        n_d.er     = r_c.er;
        for (int i = 0; i < 3; i++) begin
            n_d.prod[i] = r_c.mag[i] * r_speed_limit;
        end
    end

    t_stage_ctl                w_ctl_sq;
    logic                      w_sq_valid;
    logic [W-1:0]              w_sq_root;
    logic [$bits(t_sum)-1:0]   w_sq_side;
    t_sum                      w_s4;

    assign w_ctl_sq = '{en: w_en, valid: r_d_valid};

    pvs_isqrt #(
        .ROOT_BITS (W),
        .SIDE_BITS ($bits(t_sum))
    ) u_speed_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_sq),
        .i_x     (r_d_vsq),
        .i_side  (r_d),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    assign w_s4 = w_sq_side;

    t_stage_ctl                w_ctl_cd;
    t_cap                      w_cap_side;
    logic                      w_cd_valid;
    logic [2:0][W-2:0]         w_cd_quo;
    logic [$bits(t_cap)-1:0]   w_cd_side;
    t_cap                      w_s5;

    assign w_ctl_cd = '{en: w_en, valid: w_sq_valid};

    always_comb begin
        w_cap_side.op     = w_s4.op;
        w_cap_side.capped = w_s4.capped;
        w_cap_side.neg    = w_s4.neg;
        w_cap_side.dv     = w_s4.dv;
        w_cap_side.v      = w_s4.v;
        w_cap_side.smo    = w_s4.smo;
        w_cap_side.er     = w_s4.er;
    end

    pvs_divider #(
        .NUM_BITS  (2*W - 1),
        .DEN_BITS  (W),
        .QUO_BITS  (W - 1),
        .LANES     (3),
        .SIDE_BITS ($bits(t_cap))
    ) u_cap_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_cd),
        .i_num   (w_s4.prod),
        .i_den   (w_sq_root),
        .i_side  (w_cap_side),
        .o_valid (w_cd_valid),
        .o_quo   (w_cd_quo),
        .o_side  (w_cd_side)
    );

    assign w_s5 = w_cd_side;

    // Stage E: capped velocity, estimate, move base.
    t_fin n_e;
    t_fin r_e;
    logic r_e_valid;

    always_comb begin
        logic signed [W-1:0] qx;
        logic signed [W-1:0] vf;
        logic signed [W-1:0] half;
        n_e.op     = w_s5.op;
        n_e.capped = w_s5.capped;
        n_e.er     = w_s5.er;
        for (int i = 0; i < 3; i++) begin
            qx = {1'b0, w_cd_quo[i]};
            if (w_s5.capped) begin
                vf = w_s5.neg[i] ? -qx : qx;
            end else begin
                vf = w_s5.v[i];
            end
            half        = $signed(w_s5.smo[i]) >>> 1;
            n_e.vfin[i] = vf;
            n_e.est[i]  = f_sat((2*W+1)'(vf) + (2*W+1)'($signed(w_s5.dv[i])));
            n_e.base[i] = (W+1)'(vf) + (r_smoothing_enable ? (W+1)'(half) : '0);
        end
    end

    // Stage F: time step products.
    t_prd n_f;
    t_prd r_f;
    logic r_f_valid;

    always_comb begin
        n_f.op     = r_e.op;
        n_f.capped = r_e.capped;
        n_f.vfin   = r_e.vfin;
        n_f.est    = r_e.est;
        for (int i = 0; i < 3; i++) begin
            n_f.mv[i] = $signed({1'b0, r_dt_position}) * $signed(r_e.base[i]);
        end
        n_f.ep = $signed({1'b0, r_dt_position}) * $signed(r_e.er);
    end

    // Stage G: output register.
    t_out n_out;
    t_out r_out;
    logic r_out_valid;

    always_comb begin
        n_out.new_vel = r_f.vfin;
        n_out.capped  = r_f.capped;
        for (int i = 0; i < 3; i++) begin
            n_out.est_vel[i] = r_f.op ? '0 : r_f.est[i];
            n_out.move[i]    = r_f.op ? '0 : f_sat($signed(r_f.mv[i]) >>> F);
        end
        n_out.energy = r_f.op ? f_sat((2*W+1)'($signed(r_f.ep) >>> F)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_f_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid   <= w_d1_valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= r_c_valid;
            r_e_valid   <= w_cd_valid;
            r_f_valid   <= r_e_valid;
            r_out_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a     <= n_a;
            r_b     <= n_b;
            r_c     <= n_c;
            r_d     <= n_d;
            r_d_vsq <= n_d_vsq;
            r_e     <= n_e;
            r_f     <= n_f;
            r_out   <= n_out;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_new_vel_x   = r_out.new_vel[0];
    assign o_new_vel_y   = r_out.new_vel[1];
    assign o_new_vel_z   = r_out.new_vel[2];
    assign o_est_vel_x   = r_out.est_vel[0];
    assign o_est_vel_y   = r_out.est_vel[1];
    assign o_est_vel_z   = r_out.est_vel[2];
    assign o_move_x      = r_out.move[0];
    assign o_move_y      = r_out.move[1];
    assign o_move_z      = r_out.move[2];
    assign o_energy_step = r_out.energy;
    assign o_was_capped  = r_out.capped;

    a_cap_needs_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_capped) |-> (r_speed_limit != '0))
        else $error("Capped result while the speed limit is off.");

    a_energy_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_energy_step != '0)) |->
        ((o_move_x == '0) && (o_est_vel_x == '0) && (o_move_z == '0)))
        else $error("Energy step on an initial half-step result.");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !r_f_valid && !r_a_valid))
        else $error("Pipeline holds a word right after reset.");

endmodule

>>> dv/particle_verlet_step_with_speed_cap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_verlet_step_with_speed_cap_tb
// Streams particles through the half-step integrator in several register
// settings and idle patterns, predicts every result word in the bench and
// compares each output word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module particle_verlet_step_with_speed_cap_tb;
    import pvs_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 150;
    localparam int PHASES = 5;

    typedef struct {
        logic        op;
        logic [30:0] mass;
        logic [31:0] force_v[3];
        logic [31:0] vel[3];
        logic [31:0] smooth[3];
        logic [31:0] erate;
    } t_particle;

    typedef struct {
        logic [31:0] w[10];
        logic        capped;
    } t_step_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_stall = 1'b0;
    logic        o_valid;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = CFG_DT_POSITION;
    logic [30:0] i_cfg_data = '0;
    t_particle   cur = '{default: '0, force_v: '{default: '0}, vel: '{default: '0},
                         smooth: '{default: '0}};
    logic signed [31:0] o_w[10];
    logic        o_was_capped;

    logic [30:0] dt_pos_r = '0, dt_force_r = '0, limit_r = '0;
    logic        smooth_en_r = 1'b0;

    t_particle   pending_q[$];
    t_step_out   expected_q[$];
    int          idle_pct = 0, stall_pct = 0;
    bit          send_hold = 1'b0, taken = 1'b0, long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;
    int          long_hold_cnt = 0;
    int          cycles = 0, errors = 0, n_results = 0, n_capped = 0;
    int          n_queued = 0, n_accepted = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    particle_verlet_step_with_speed_cap dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(cur.op), .i_mass(cur.mass),
        .i_force_x(cur.force_v[0]), .i_force_y(cur.force_v[1]),
        .i_force_z(cur.force_v[2]),
        .i_vel_x(cur.vel[0]), .i_vel_y(cur.vel[1]), .i_vel_z(cur.vel[2]),
        .i_smooth_x(cur.smooth[0]), .i_smooth_y(cur.smooth[1]),
        .i_smooth_z(cur.smooth[2]), .i_energy_rate(cur.erate),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_new_vel_x(o_w[0]), .o_new_vel_y(o_w[1]), .o_new_vel_z(o_w[2]),
        .o_est_vel_x(o_w[3]), .o_est_vel_y(o_w[4]), .o_est_vel_z(o_w[5]),
        .o_move_x(o_w[6]), .o_move_y(o_w[7]), .o_move_z(o_w[8]),
        .o_energy_step(o_w[9]), .o_was_capped(o_was_capped),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    function automatic longint sat(longint x);
        if (x > WMAX) return WMAX;
        if (x < WMIN) return WMIN;
        return x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return sat(p >>> 16);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_step_out half_step(t_particle p);
        t_step_out    r;
        longint       dtfm, dv[3], v[3], base;
        longint unsigned vsq, a, q, mag, lim;
        vsq = 0;
        lim = limit_r;
        r.capped = 1'b0;
        if (p.mass == 0) begin
            dtfm = WMAX;
        end else begin
            q = (longint'(dt_force_r) << 16) / longint'(p.mass);
            dtfm = (q > WMAX) ? WMAX : longint'(q);
        end
        for (int i = 0; i < 3; i++) begin
            dv[i] = qmul(dtfm, longint'(signed'(p.force_v[i])));
            v[i] = sat(longint'(signed'(p.vel[i])) + dv[i]);
            a = (v[i] < 0) ? -v[i] : v[i];
            vsq += a * a;
        end
        if (lim != 0 && vsq > lim * lim) begin
            mag = int_sqrt(vsq);
            r.capped = 1'b1;
            for (int i = 0; i < 3; i++) begin
                a = (v[i] < 0) ? -v[i] : v[i];
                q = a * lim / mag;
                v[i] = sat((v[i] < 0) ? -longint'(q) : longint'(q));
            end
        end
        for (int i = 0; i < 3; i++) begin
            r.w[i] = v[i][31:0];
            r.w[3+i] = '0;
            r.w[6+i] = '0;
            if (!p.op) begin
                r.w[3+i] = 32'(sat(v[i] + dv[i]));
                base = v[i];
                if (smooth_en_r) base += longint'(signed'(p.smooth[i])) >>> 1;
                r.w[6+i] = 32'(qmul(longint'(dt_pos_r), base));
            end
        end
        r.w[9] = p.op ? 32'(qmul(longint'(dt_pos_r), longint'(signed'(p.erate)))) : 32'd0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("particle_verlet_step_with_speed_cap_tb failed");
            $finish;
        end
    end

    // Receiver hold-off, counted here so that the sender keeps offering words.
    always @(posedge i_clk) begin
        if (long_hold_cnt > 0) begin
            long_hold_cnt <= long_hold_cnt - 1;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_cnt <= 400;
            long_hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_step_out e;
        if (i_rst_n && i_valid && !o_stall) begin
            taken = 1'b1;
            n_accepted++;
            expected_q.push_back(half_step(cur));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (o_was_capped) n_capped++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word at cycle %0d", cycles);
            end else begin
                e = expected_q.pop_front();
                for (int i = 0; i <= 10; i++) begin
                    if ((i < 10) ? (o_w[i] !== e.w[i]) : (o_was_capped !== e.capped)) begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d field %0d: expected %h, got %h",
                                     n_results, i, (i < 10) ? e.w[i] : {31'd0, e.capped},
                                     (i < 10) ? o_w[i] : {31'd0, o_was_capped});
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= (long_hold_cnt > 0) || ($urandom_range(99) < stall_pct);
        if (!i_valid || taken) begin
            taken = 1'b0;
            if (i_rst_n && !send_hold && pending_q.size() > 0
                    && $urandom_range(99) >= idle_pct) begin
                cur <= pending_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic cfg_write(t_cfg_index idx, logic [30:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_DT_POSITION:   dt_pos_r = data;
            CFG_DT_FORCE_HALF: dt_force_r = data;
            CFG_SPEED_LIMIT:   limit_r = data;
            default:           smooth_en_r = data[0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_word();
        logic [31:0] ext[5] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff};
        case ($urandom_range(4))
            0: return $urandom;
            1: return ext[$urandom_range(4)];
            2: return $urandom_range(32'h1fffff) - 32'h100000;
            default: return $urandom_range(32'h3ffffff) - 32'h2000000;
        endcase
    endfunction

    function automatic t_particle rnd_particle();
        t_particle p;
        p.op = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: p.mass = 31'($urandom);
            1: p.mass = 31'($urandom_range(32'h40000, 32'h4000));
            2: p.mass = 31'($urandom_range(16, 1));
            default: p.mass = 31'h7fffffff;
        endcase
        for (int i = 0; i < 3; i++) begin
            p.force_v[i] = rnd_word();
            p.vel[i] = rnd_word();
            p.smooth[i] = rnd_word();
        end
        p.erate = rnd_word();
        return p;
    endfunction

    task automatic push(t_particle p);
        pending_q.push_back(p);
        n_queued++;
    endtask

    initial begin
        logic [31:0] corner[7] = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff,
                                   32'h80000000, 32'h10000, 32'hffff0000};
        logic [30:0] mass_set[4] = '{31'd0, 31'd1, 31'h7fffffff, 31'h10000};
        logic [30:0] dtp_set[PHASES] = '{31'h10000, 31'h7fffffff, 31'd0, 31'h800, 31'd0};
        logic [30:0] dtf_set[PHASES] = '{31'h8000, 31'h7fffffff, 31'd0, 31'h4000, 31'd0};
        logic [30:0] lim_set[PHASES] = '{31'h00a00000, 31'h7fffffff, 31'd0, 31'h1000, 31'd0};
        int idle_set[PHASES] = '{0, 69, 0, 21, 0};
        int stall_set[PHASES] = '{0, 0, 69, 21, 0};
        t_particle p;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            cfg_write(CFG_DT_POSITION, (ph == 4) ? 31'($urandom) : dtp_set[ph]);
            cfg_write(CFG_DT_FORCE_HALF, (ph == 4) ? 31'($urandom) : dtf_set[ph]);
            cfg_write(CFG_SPEED_LIMIT, (ph == 4) ? 31'($urandom_range(32'h2000000)) : lim_set[ph]);
            cfg_write(CFG_SMOOTHING, (ph == 4) ? 31'($urandom_range(1)) : 31'(ph % 2 == 0));
            idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            if (ph == 0) begin
                for (int k = 0; k < 14; k++) begin
                    p.op = k[0];
                    p.mass = mass_set[k % 4];
                    for (int i = 0; i < 3; i++) begin
                        p.force_v[i] = corner[(k / 2 + i) % 7];
                        p.vel[i] = corner[(k / 2 + i + 1) % 7];
                        p.smooth[i] = corner[(k / 2 + i + 2) % 7];
                    end
                    p.erate = corner[(k / 2 + 3) % 7];
                    push(p);
                end
                p = '{op: 1'b0, mass: 31'h10000, force_v: '{default: '0},
                      vel: '{32'h00c00000, 32'hff400000, 32'h00100000},
                      smooth: '{default: 32'h00020000}, erate: 32'h0};
                push(p);
                p.vel = '{32'h00050000, 32'h0, 32'h0};
                push(p);
            end
            for (int n = 0; n < 330; n++) begin
                push(rnd_particle());
                if (ph == 1 && n == 160) begin
                    wait_drained();
                    send_hold = 1'b1;
                    repeat (20) @(posedge i_clk);
                    send_hold = 1'b0;
                end
                if (ph == 4 && n == 100) long_hold_req = 1'b1;
            end
            wait_drained();
            long_hold_req = 1'b0;
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d particles checked over %0d register settings, %0d capped.",
                 n_results, PHASES, n_capped);
        if (errors == 0) begin
            $display("particle_verlet_step_with_speed_cap_tb passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("particle_verlet_step_with_speed_cap_tb failed");
        end
        $finish;
    end
endmodule

>>> files.f
src/pvs_pkg.sv
src/pvs_divider.sv
src/pvs_isqrt.sv
src/particle_verlet_step_with_speed_cap.sv
dv/particle_verlet_step_with_speed_cap_tb.sv
